// ----- src/bim_pkg.sv -----
`timescale 1ns / 1ps

package bim_pkg;

   // Array size and derived geometry.
   localparam int NUM_INPUTS    = 64;
   localparam int NUM_STATIONS  = NUM_INPUTS / 2;
   localparam int NUM_HALF      = NUM_STATIONS / 2;
   localparam int CHAN_LEN      = ((16 * NUM_INPUTS) / 4 * (NUM_INPUTS / 4 + 1)) / 2;
   localparam int QUAD_SIZE     = ((NUM_STATIONS / 2 + 1) * NUM_STATIONS) / 4;
   localparam int ORD_TRI       = ((NUM_HALF + 1) * NUM_HALF) / 2;
   localparam int ORD_LAST      = 4 * ORD_TRI - NUM_HALF - 1;
   localparam int ORD_WORDS     = 8 * (ORD_LAST + 1);

   // Field widths.
   localparam int INPUT_W  = 6;
   localparam int ANT_W    = INPUT_W - 1;
   localparam int CHAN_W   = 8;
   localparam int CELL_W   = 10;
   localparam int TILE_W   = CELL_W + 2;
   localparam int REAL_W   = 20;
   localparam int IMAG_W   = 25;
   localparam int ORD_W    = 13;
   localparam int OFFSET_W = 24;

   localparam logic [OFFSET_W-1:0] IMAG_OFFSET_RESET = OFFSET_W'(557056);

   // Payload leaving the first pipeline stage.
   typedef struct packed {
      logic              pair_ok;
      logic [CHAN_W-1:0] channel;
      logic [TILE_W-1:0] tile_word;
      logic [ORD_W-1:0]  ord_word;
   } bim_s1_type;

   // Triangular number i*(i+1)/2 for an antenna-sized argument.
   function automatic logic [CELL_W-1:0] tri_num(input logic [ANT_W-1:0] i);
      logic [2*ANT_W:0] prod;
      prod = (2*ANT_W+1)'(i) * ((2*ANT_W+1)'(i) + (2*ANT_W+1)'(1));
      return CELL_W'(prod >> 1);
   endfunction

endpackage

// ----- src/bim_cell_stage.sv -----
`timescale 1ns / 1ps

module bim_cell_stage import bim_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [INPUT_W-1:0] first_input,
   input  logic [INPUT_W-1:0] second_input,
   input  logic [CHAN_W-1:0]  channel,
   output logic               s1_valid,
   output bim_s1_type         s1
);

   logic [ANT_W-1:0]  a0, a1, diff, top_i;
   logic              p0, p1;
   logic [1:0]        quad;
   logic [CELL_W-1:0] tile_cell, ord_cell;
   logic [CELL_W-1:0] top_cell, mid_cell, bot_cell;
   bim_s1_type        s1_in, s1_ff;
   logic              valid_ff;

   // Split the input numbers into antenna and polarisation.
   assign a0   = first_input[INPUT_W-1:1];
   assign a1   = second_input[INPUT_W-1:1];
   assign p0   = first_input[0];
   assign p1   = second_input[0];
   assign quad = {a0[0], a1[0]};
   assign diff = a1 - a0;

   // Tile cell: quadrant block plus the triangular offset of the halved antennas.
   assign tile_cell = CELL_W'(CELL_W'(quad) * CELL_W'(QUAD_SIZE))
                    + tri_num(a1 >> 1) + CELL_W'(a0 >> 1);

   // Ordered cell for the top triangle, middle rectangle and bottom triangle.
   assign top_i    = ANT_W'(NUM_HALF - 2) - a0;
   assign top_cell = CELL_W'(ORD_LAST) - tri_num(top_i)
                   - CELL_W'(ANT_W'(NUM_STATIONS - 1) - a1);
   assign mid_cell = tri_num(a1) + CELL_W'(a0);
   assign bot_cell = CELL_W'(ORD_TRI)
                   + CELL_W'(CELL_W'(a1 - ANT_W'(NUM_HALF)) * CELL_W'(NUM_HALF + 1))
                   + CELL_W'(NUM_HALF) - CELL_W'(diff);

   always_comb begin
      if (CELL_W'(diff) > CELL_W'(NUM_HALF)) begin
         ord_cell = top_cell;
      end else if (CELL_W'(a1) < CELL_W'(NUM_HALF)) begin
         ord_cell = mid_cell;
      end else begin
         ord_cell = bot_cell;
      end
   end

   // Assemble the next stage contents.
   always_comb begin
      s1_in.pair_ok   = (a1 >= a0);
      s1_in.channel   = channel;
      s1_in.tile_word = {tile_cell, p1, p0};
      s1_in.ord_word  = {ord_cell, p0 ^ p1, p0, 1'b0};
   end

   // Stage register: valid is reset, payload is not.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
   end

   assign s1_valid = valid_ff;
   assign s1       = s1_ff;

endmodule

// ----- src/correlator_baseline_index_map_top.sv -----
// An accepted beat passes the registers of stages one to four before rsp_strobe goes high.
// Throughput: one beat per cycle while busy is low; the four register stages take a new pair on every edge.
// The channel-length product is the deepest step and has a stage of its own.
// Reset is synchronous: it clears all valid bits, loads the default imaginary offset
// and holds busy high until the cycle after reset is released.
`timescale 1ns / 1ps

module correlator_baseline_index_map_top import bim_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [INPUT_W-1:0]  req_first_input,
   input  logic [INPUT_W-1:0]  req_second_input,
   input  logic [CHAN_W-1:0]   req_channel,
   output logic                rsp_strobe,
   output logic                rsp_pair_valid,
   output logic [REAL_W-1:0]   rsp_tile_real_word,
   output logic [IMAG_W-1:0]   rsp_tile_imag_word,
   output logic [ORD_W-1:0]    rsp_ordered_word,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [OFFSET_W-1:0] csr_imag_offset
);

   logic                busy_ff;
   logic [OFFSET_W-1:0] offset_ff;
   logic                accept;
   logic                s1_valid;
   bim_s1_type          s1;

   logic                s2_valid_ff, s2_pair_ff;
   logic [REAL_W-1:0]   s2_base_ff, s2_base_in;
   logic [TILE_W-1:0]   s2_tile_ff;
   logic [ORD_W-1:0]    s2_ord_ff;

   logic                s3_valid_ff, s3_pair_ff;
   logic [REAL_W-1:0]   s3_real_ff, s3_real_in;
   logic [ORD_W-1:0]    s3_ord_ff;

   logic                out_strobe_ff, out_pair_ff;
   logic [REAL_W-1:0]   out_real_ff, out_real_in;
   logic [IMAG_W-1:0]   out_imag_ff, out_imag_in;
   logic [ORD_W-1:0]    out_ord_ff, out_ord_in;

   assign accept    = start && !busy_ff;
   assign busy      = busy_ff;
   assign csr_ready = !busy_ff;

   // Busy flag and configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b1;
         offset_ff <= IMAG_OFFSET_RESET;
      end else begin
         busy_ff <= 1'b0;
         if (csr_valid && csr_ready) begin
            offset_ff <= csr_imag_offset;
         end
      end
   end

   // Stage one: cell indices.
   bim_cell_stage u_cell (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .first_input  (req_first_input),
      .second_input (req_second_input),
      .channel      (req_channel),
      .s1_valid     (s1_valid),
      .s1           (s1)
   );

   // Stage two: channel base address.
   assign s2_base_in = REAL_W'(REAL_W'(s1.channel) * REAL_W'(CHAN_LEN));

   // Stage three: real tile word.
   assign s3_real_in = s2_base_ff + REAL_W'(s2_tile_ff);

   // Stage four: imaginary word and zeroing of rejected pairs.
   always_comb begin
      if (s3_pair_ff) begin
         out_real_in = s3_real_ff;
         out_imag_in = IMAG_W'(s3_real_ff) + IMAG_W'(offset_ff);
         out_ord_in  = s3_ord_ff;
      end else begin
         out_real_in = '0;
         out_imag_in = '0;
         out_ord_in  = '0;
      end
   end

   // Valid bits of the later stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff   <= 1'b0;
         s3_valid_ff   <= 1'b0;
         out_strobe_ff <= 1'b0;
      end else begin
         s2_valid_ff   <= s1_valid;
         s3_valid_ff   <= s2_valid_ff;
         out_strobe_ff <= s3_valid_ff;
      end
   end

   // Payload registers of the later stages.
   always_ff @(posedge clock) begin
      s2_pair_ff  <= s1.pair_ok;
      s2_base_ff  <= s2_base_in;
      s2_tile_ff  <= s1.tile_word;
      s2_ord_ff   <= s1.ord_word;
      s3_pair_ff  <= s2_pair_ff;
      s3_real_ff  <= s3_real_in;
      s3_ord_ff   <= s2_ord_ff;
      out_pair_ff <= s3_pair_ff;
      out_real_ff <= out_real_in;
      out_imag_ff <= out_imag_in;
      out_ord_ff  <= out_ord_in;
   end

   assign rsp_strobe         = out_strobe_ff;
   assign rsp_pair_valid     = out_pair_ff;
   assign rsp_tile_real_word = out_real_ff;
   assign rsp_tile_imag_word = out_imag_ff;
   assign rsp_ordered_word   = out_ord_ff;

   // Every accepted beat leaves the pipeline with rsp_strobe high.
   a_latency : assert property (@(posedge clock) disable iff (reset)
      accept |-> ##4 rsp_strobe)
      else $error("accepted beat did not reach the result port");

   // The valid flag follows the antenna order of the beat that produced the strobe.
   a_pair_order : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_pair_valid ==
         ($past(req_second_input[INPUT_W-1:1], 4) >= $past(req_first_input[INPUT_W-1:1], 4)))
      else $error("pair valid flag does not match antenna order");

   // A rejected pair carries all-zero addresses.
   a_zero_reject : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_pair_valid) |->
         (rsp_tile_real_word == '0 && rsp_tile_imag_word == '0 && rsp_ordered_word == '0))
      else $error("rejected pair has non-zero addresses");

   // Ordered index stays within one channel section.
   a_ord_range : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_pair_valid) |-> (rsp_ordered_word < ORD_W'(ORD_WORDS)))
      else $error("ordered word beyond the channel section");

endmodule
